// File: sv/sync_length_frame_deframer_sum16_top_assert.svh
// Assertion macros shared by the checker of the deframer.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_SUM16_TOP_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_SUM16_TOP_ASSERT_SVH

// Concurrent assertion that is switched off while reset is high.
`define SLFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds around reset.
`define SLFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/slfd_pkg.sv
package slfd_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_CK_ERR  = 2'd2;
   localparam logic [1:0] KIND_LEN_ERR = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
   localparam logic [1:0] REG_MIN_PAYLOAD = 2'd2;
   localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

   localparam int          REPLAY_LEN  = 5;
   localparam logic [2:0]  REPLAY_LAST = 3'(REPLAY_LEN - 1);
   localparam logic [2:0]  LEN_SLOT    = 3'd4;
   localparam logic [8:0]  SEQ_BYTES   = 9'd4;

   typedef enum logic [6:0] {
      PH_HUNT0 = 7'b000_0001,
      PH_HUNT1 = 7'b000_0010,
      PH_SEQ   = 7'b000_0100,
      PH_LEN   = 7'b000_1000,
      PH_DATA  = 7'b001_0000,
      PH_CKLO  = 7'b010_0000,
      PH_CKHI  = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] min_payload;
      logic [7:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic       step;
      logic       replay;
      logic [2:0] replay_idx;
      logic       emit;
      phase_type  phase;
   } cmd_type;

   typedef struct packed {
      logic is_sf;
      logic is_ss;
      logic seq_done;
      logic len_bad;
      logic len_zero;
      logic data_done;
   } status_type;

endpackage

// File: sv/slfd_if.sv
interface slfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [31:0] frame_sequence;
   logic [7:0]  frame_length;
   logic        last;

   modport source (output valid, output kind, output payload_byte, output frame_sequence,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input frame_sequence,
                   input frame_length, input last, output ready);
endinterface

// File: sv/slfd_csr.sv
module slfd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output slfd_pkg::cfg_type cfg
);
   import slfd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [7:0] rd_byte;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SYNC_FIRST:  cfg_in.sync_first  = pwdata[7:0];
            REG_SYNC_SECOND: cfg_in.sync_second = pwdata[7:0];
            REG_MIN_PAYLOAD: cfg_in.min_payload = pwdata[7:0];
            REG_MAX_PAYLOAD: cfg_in.max_payload = pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SYNC_FIRST:  rd_byte = cfg_ff.sync_first;
         REG_SYNC_SECOND: rd_byte = cfg_ff.sync_second;
         REG_MIN_PAYLOAD: rd_byte = cfg_ff.min_payload;
         REG_MAX_PAYLOAD: rd_byte = cfg_ff.max_payload;
         default:         rd_byte = 8'd0;
      endcase
   end

   assign prdata = {24'd0, rd_byte};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{sync_first: 8'd0, sync_second: 8'd0,
                     min_payload: 8'd0, max_payload: 8'd255};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/slfd_ctrl.sv
module slfd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  slfd_pkg::status_type status,
   output slfd_pkg::cmd_type    cmd
);
   import slfd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       replay_ff, replay_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step;
   logic       emit;

   // No new item while replaying or while the single result register is full and not being drained.
   assign req_ready = !replay_ff && (!rsp_valid_ff || rsp_ready);
   assign step      = (req_valid && req_ready) || replay_ff;

   always_comb begin
      phase_in  = phase_ff;
      replay_in = replay_ff;
      idx_in    = idx_ff;
      emit      = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (status.is_ss) begin
                  phase_in = PH_SEQ;
               end else if (!status.is_sf) begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_SEQ: begin
               if (status.seq_done) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (status.len_bad) begin
                  phase_in  = PH_HUNT0;
                  emit      = 1'b1;
                  replay_in = 1'b1;
                  idx_in    = 3'd0;
               end else if (status.len_zero) begin
                  phase_in = PH_CKLO;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               emit = 1'b1;
               if (status.data_done) begin
                  phase_in = PH_CKLO;
               end
            end
            PH_CKLO: phase_in = PH_CKHI;
            PH_CKHI: begin
               emit     = 1'b1;
               phase_in = PH_HUNT0;
            end
            default: phase_in = status.is_sf ? PH_HUNT1 : PH_HUNT0;
         endcase
         // Advance the replay pointer; the replay itself never reaches LEN.
         if (replay_ff) begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == REPLAY_LAST) begin
               replay_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign cmd.step       = step;
   assign cmd.replay     = replay_ff;
   assign cmd.replay_idx = idx_ff;
   assign cmd.emit       = emit;
   assign cmd.phase      = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT0;
         replay_ff    <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         replay_ff    <= replay_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/slfd_dp.sv
module slfd_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  slfd_pkg::cfg_type    cfg,
   input  slfd_pkg::cmd_type    cmd,
   input  logic [7:0]           rx_byte,
   output slfd_pkg::status_type status,
   output logic [1:0]           kind,
   output logic [7:0]           payload_byte,
   output logic [31:0]          frame_sequence,
   output logic [7:0]           frame_length,
   output logic                 last
);
   import slfd_pkg::*;

   logic [7:0]  bc_ff, bc_in;
   logic [31:0] seq_ff, seq_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  cklo_ff, cklo_in;
   logic [7:0]  store_ff [REPLAY_LEN];

   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  pay_ff, pay_in;
   logic [31:0] oseq_ff;
   logic [7:0]  olen_ff, olen_in;
   logic        last_ff, last_in;

   logic [7:0]  cur;
   logic [8:0]  bc_next;
   logic        ck_match;
   logic        store_we;
   logic [2:0]  store_idx;

   // During replay the byte comes from the store; writes into the store only
   // ever land below the entry being replayed, so no copy is needed.
   assign cur      = cmd.replay ? store_ff[cmd.replay_idx] : rx_byte;
   assign bc_next  = {1'b0, bc_ff} + 9'd1;
   assign ck_match = ({cur, cklo_ff} == sum_ff);

   assign status.is_sf     = (cur == cfg.sync_first);
   assign status.is_ss     = (cur == cfg.sync_second);
   assign status.seq_done  = (bc_next >= SEQ_BYTES);
   assign status.len_bad   = (cur < cfg.min_payload) || (cur > cfg.max_payload);
   assign status.len_zero  = (cur == 8'd0);
   assign status.data_done = (bc_next >= {1'b0, len_ff});

   always_comb begin
      bc_in     = bc_ff;
      seq_in    = seq_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      cklo_in   = cklo_ff;
      store_we  = 1'b0;
      store_idx = {1'b0, bc_ff[1:0]};
      if (cmd.step) begin
         unique case (cmd.phase)
            PH_HUNT1: begin
               if (status.is_ss) begin
                  bc_in  = 8'd0;
                  seq_in = 32'd0;
                  sum_in = {8'd0, cfg.sync_first} + {8'd0, cfg.sync_second};
               end
            end
            PH_SEQ: begin
               store_we = 1'b1;
               seq_in   = seq_ff | ({24'd0, cur} << {bc_ff[1:0], 3'b000});
               sum_in   = sum_ff + {8'd0, cur};
               bc_in    = bc_next[7:0];
            end
            PH_LEN: begin
               store_we  = 1'b1;
               store_idx = LEN_SLOT;
               len_in    = cur;
               sum_in    = sum_ff + {8'd0, cur};
               if (!status.len_bad) begin
                  bc_in = 8'd0;
               end
            end
            PH_DATA: begin
               sum_in = sum_ff + {8'd0, cur};
               bc_in  = bc_next[7:0];
            end
            PH_CKLO: cklo_in = cur;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cmd.phase)
         PH_DATA: begin
            kind_in = KIND_PAYLOAD;
            pay_in  = cur;
            olen_in = len_ff;
            last_in = 1'b0;
         end
         PH_LEN: begin
            kind_in = KIND_LEN_ERR;
            pay_in  = 8'd0;
            olen_in = cur;
            last_in = 1'b1;
         end
         default: begin
            kind_in = ck_match ? KIND_GOOD : KIND_CK_ERR;
            pay_in  = 8'd0;
            olen_in = len_ff;
            last_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff   <= 8'd0;
         seq_ff  <= 32'd0;
         len_ff  <= 8'd0;
         sum_ff  <= 16'd0;
         cklo_ff <= 8'd0;
      end else begin
         bc_ff   <= bc_in;
         seq_ff  <= seq_in;
         len_ff  <= len_in;
         sum_ff  <= sum_in;
         cklo_ff <= cklo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= cur;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff <= kind_in;
         pay_ff  <= pay_in;
         oseq_ff <= seq_ff;
         olen_ff <= olen_in;
         last_ff <= last_in;
      end
   end

   assign kind           = kind_ff;
   assign payload_byte   = pay_ff;
   assign frame_sequence = oseq_ff;
   assign frame_length   = olen_ff;
   assign last           = last_ff;

endmodule

// File: sv/sync_length_frame_deframer_sum16_top.sv
// Byte-stream deframer. Each input item is one received byte. The block hunts
// for the two configured sync bytes, collects a four-byte little-endian
// sequence number and a one-byte payload length, passes each payload byte on
// as a result item, and closes the frame with a 16-bit little-endian additive
// checksum over the sync, sequence, length and payload bytes, reporting frame
// good or checksum error together with the sequence and length. A length
// outside the configured minimum to maximum range is reported as a length
// error, and the five bytes that followed the sync pair are then fed back
// through the sync hunter from a small local store. One byte is taken per
// clock cycle when the input is not held off; after a length error the input
// stays stalled during that replay. Results sit in a single output register,
// so the input is also held off while a result waits to be taken. Registers
// sync_first, sync_second, min_payload and max_payload sit at byte addresses
// 0, 4, 8 and 12 of the APB-style port and must be written while idle.
module sync_length_frame_deframer_sum16_top (
   input  logic        clock,
   input  logic        reset,
   slfd_req_if.sink    req_if,
   slfd_rsp_if.source  rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import slfd_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Configuration registers.
   slfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller owns the frame phase, the replay sequencing and both
   // handshakes; it tells the datapath what each byte means.
   slfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the counters, the sequence and checksum accumulators,
   // the replay store and the result register.
   slfd_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .rx_byte        (req_if.rx_byte),
      .status         (status),
      .kind           (rsp_if.kind),
      .payload_byte   (rsp_if.payload_byte),
      .frame_sequence (rsp_if.frame_sequence),
      .frame_length   (rsp_if.frame_length),
      .last           (rsp_if.last)
   );

endmodule

// File: sv/slfd_checker.sv
`include "sync_length_frame_deframer_sum16_top_assert.svh"

module slfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] kind,
   input logic [7:0] payload_byte,
   input logic       last
);
   import slfd_pkg::*;

   logic rsp_stall;
   logic rsp_payload;
   logic rsp_end;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = rsp_valid && (kind == KIND_PAYLOAD);
   assign rsp_end     = rsp_valid && (kind != KIND_PAYLOAD);

   `SLFD_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "result dropped while stalled")
   `SLFD_ASSERT(a_no_accept_full, clock, reset, rsp_stall |-> !req_ready, "item taken while full")
   `SLFD_ASSERT(a_payload_not_last, clock, reset, rsp_payload |-> !last, "payload marked last")
   `SLFD_ASSERT(a_end_fields, clock, reset, rsp_end |-> last && payload_byte == 8'd0, "bad end item")
   `SLFD_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind sync_length_frame_deframer_sum16_top slfd_checker u_slfd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .kind         (rsp_if.kind),
   .payload_byte (rsp_if.payload_byte),
   .last         (rsp_if.last)
);

// File: tb/tb_sync_length_frame_deframer_sum16_top.sv
// Self-checking bench for the sync-header, length-framed byte deframer.
module tb_sync_length_frame_deframer_sum16_top;
   import slfd_pkg::*;

   // The run is stopped here if the block hangs.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // Cycles left after the last expected result before registers are touched:
   // a length error is followed by a replay that yields no result.
   localparam int unsigned SETTLE_CYCLES = 10;
   // Length of the receiver hold-off that makes the block back up.
   localparam int unsigned HOLD_CYCLES = 90;
   // Only the first mismatches are printed; all of them are counted.
   localparam int unsigned SHOWN_MISMATCHES = 40;

   // One result item as the block presents it.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [31:0] frame_sequence;
      logic [7:0]  frame_length;
      logic        last;
   } deframe_result_t;

   // One row of the directed script. A pinned row carries its result typed in
   // by hand; every other row is checked against the predictor.
   typedef struct {
      logic [7:0]      rx_byte;
      bit              pinned;
      deframe_result_t want;
   } directed_row_t;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   slfd_req_if req_if ();
   slfd_rsp_if rsp_if ();

   sync_length_frame_deframer_sum16_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the registers and of the deframer state, as the bench
   // believes them to be. The phase uses the package's one-hot encoding.
   cfg_type     csr_shadow;
   phase_type   hunt_phase;
   logic [7:0]  count_bytes;
   logic [31:0] seq_word;
   logic [7:0]  held_length;
   logic [15:0] byte_sum;
   logic [7:0]  check_lo;
   logic [7:0]  header_copy [5];

   // Results that the block still owes, oldest first.
   deframe_result_t pending_results [$];

   // A pinned expectation for the item currently offered by the sender.
   bit              pin_on;
   deframe_result_t pin_res;

   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;
   bit          hold_request;
   int unsigned items_sent;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   directed_row_t script [$];

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Builds a result the way the block reports it; last is set for every
   // kind except a payload byte.
   function automatic deframe_result_t make_result(input logic [1:0] kind,
                                                   input logic [7:0] data);
      deframe_result_t r;
      r.kind           = kind;
      r.payload_byte   = data;
      r.frame_sequence = seq_word;
      r.frame_length   = held_length;
      r.last           = (kind != KIND_PAYLOAD);
      return r;
   endfunction

   // Advances the deframer by one byte. Returns 1 when the byte yields a
   // result, which is then placed in r.
   function automatic bit deframe_step(input logic [7:0] b, output deframe_result_t r);
      logic [15:0] received;
      r = '0;
      case (hunt_phase)
         PH_HUNT1: begin
            // The earliest matching pair wins: a repeated first sync byte keeps
            // the hunter waiting for the second one.
            if (b == csr_shadow.sync_second) begin
               hunt_phase  = PH_SEQ;
               count_bytes = 8'd0;
               seq_word    = 32'd0;
               byte_sum    = 16'(csr_shadow.sync_first) + 16'(csr_shadow.sync_second);
            end else if (b != csr_shadow.sync_first) begin
               hunt_phase = PH_HUNT0;
            end
            return 1'b0;
         end
         PH_SEQ: begin
            header_copy[count_bytes[1:0]] = b;
            seq_word    = seq_word | (32'(b) << (8 * count_bytes[1:0]));
            byte_sum    = byte_sum + 16'(b);
            count_bytes = count_bytes + 8'd1;
            if (count_bytes >= 8'd4) hunt_phase = PH_LEN;
            return 1'b0;
         end
         PH_LEN: begin
            held_length    = b;
            header_copy[4] = b;
            byte_sum       = byte_sum + 16'(b);
            if (b < csr_shadow.min_payload || b > csr_shadow.max_payload) begin
               hunt_phase = PH_HUNT0;
               r = make_result(KIND_LEN_ERR, 8'd0);
               return 1'b1;
            end
            count_bytes = 8'd0;
            // A zero length goes straight on to the checksum.
            hunt_phase  = (b == 8'd0) ? PH_CKLO : PH_DATA;
            return 1'b0;
         end
         PH_DATA: begin
            byte_sum    = byte_sum + 16'(b);
            count_bytes = count_bytes + 8'd1;
            if (count_bytes >= held_length) hunt_phase = PH_CKLO;
            r = make_result(KIND_PAYLOAD, b);
            return 1'b1;
         end
         PH_CKLO: begin
            check_lo   = b;
            hunt_phase = PH_CKHI;
            return 1'b0;
         end
         PH_CKHI: begin
            received   = {b, check_lo};
            hunt_phase = PH_HUNT0;
            r = make_result((received == byte_sum) ? KIND_GOOD : KIND_CK_ERR, 8'd0);
            return 1'b1;
         end
         default: begin
            hunt_phase = (b == csr_shadow.sync_first) ? PH_HUNT1 : PH_HUNT0;
            return 1'b0;
         end
      endcase
   endfunction

   // Takes one accepted byte. After a length error the five header bytes are
   // run through the hunter again; that replay never yields a result. A
   // result is queued as predicted unless the script pinned it by hand.
   function automatic void absorb_byte(input logic [7:0] b);
      deframe_result_t r;
      deframe_result_t scratch;
      logic [7:0]      again [5];
      bit              produced;
      produced = deframe_step(b, r);
      if (produced && r.kind == KIND_LEN_ERR) begin
         again      = header_copy;
         hunt_phase = PH_HUNT0;
         for (int i = 0; i < 5; i++) void'(deframe_step(again[i], scratch));
      end
      if (produced) pending_results.push_back(pin_on ? pin_res : r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= SHOWN_MISMATCHES)
         $display("mismatch at cycle %0d: %s got %0h, expected %0h",
                  cycle_count, what, got, want);
   endtask

   // Both handshakes are observed here, at the rising edge, so that a
   // prediction is always queued before any result it might be compared with.
   always @(posedge clock) begin
      deframe_result_t want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) absorb_byte(req_if.rx_byte);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with nothing outstanding, kind", 32'(rsp_if.kind), 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_if.kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_if.kind), 32'(want.kind));
               if (rsp_if.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 32'(rsp_if.payload_byte),
                                  32'(want.payload_byte));
               if (rsp_if.frame_sequence !== want.frame_sequence)
                  report_mismatch("frame_sequence", rsp_if.frame_sequence,
                                  want.frame_sequence);
               if (rsp_if.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 32'(rsp_if.frame_length),
                                  32'(want.frame_length));
               if (rsp_if.last !== want.last)
                  report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
            end
         end
      end
   end

   // Receiver. It stalls at random at the current rate, except while a
   // hold-off runs, during which it refuses every result so that the block
   // backs up and stalls its input.
   initial begin
      int unsigned hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog. Reaching the limit means the block stopped making progress.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Offers one byte, after random idle cycles, and returns at the falling
   // edge after it was taken. valid stays high so that back-to-back items
   // need no toggle.
   task automatic push_byte(input logic [7:0] value, input bit pinned,
                            input deframe_result_t pinned_res);
      while ($urandom_range(99) < send_gap_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      pin_on         = pinned;
      pin_res        = pinned_res;
      req_if.rx_byte = value;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Register write over the APB-style port: a setup cycle, then an access
   // cycle that completes at the edge where pready is seen high.
   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = {24'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_SYNC_FIRST:  csr_shadow.sync_first  = value;
         REG_SYNC_SECOND: csr_shadow.sync_second = value;
         REG_MIN_PAYLOAD: csr_shadow.min_payload = value;
         REG_MAX_PAYLOAD: csr_shadow.max_payload = value;
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Lets the block run dry: every owed result has to arrive, then it is given
   // time to settle in case a replay after a length error is still in progress.
   task automatic drain_block();
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sends either a short burst of noise or a frame built for the current
   // settings. Most frames are well formed with small payloads; some carry a
   // bad checksum, a length out of range, the largest allowed length, or are
   // cut short.
   task automatic send_random_unit();
      logic [7:0]  frame_bytes [$];
      logic [7:0]  b;
      logic [7:0]  len;
      logic [15:0] sum;
      int unsigned pick;
      int unsigned span;
      int unsigned cut;
      pick = $urandom_range(99);
      if (pick < 12) begin
         repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom));
      end else begin
         if ($urandom_range(9) == 0) frame_bytes.push_back(csr_shadow.sync_first);
         frame_bytes.push_back(csr_shadow.sync_first);
         frame_bytes.push_back(csr_shadow.sync_second);
         sum = 16'(csr_shadow.sync_first) + 16'(csr_shadow.sync_second);
         repeat (4) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            sum = sum + 16'(b);
         end
         pick = $urandom_range(99);
         if (csr_shadow.min_payload <= csr_shadow.max_payload && pick < 85) begin
            span = csr_shadow.max_payload - csr_shadow.min_payload;
            if (span > 12) span = 12;
            len = 8'(csr_shadow.min_payload + $urandom_range(span));
         end else if (pick < 90) begin
            len = csr_shadow.max_payload;
         end else begin
            len = 8'($urandom);
         end
         frame_bytes.push_back(len);
         sum = sum + 16'(len);
         if (len >= csr_shadow.min_payload && len <= csr_shadow.max_payload) begin
            repeat (len) begin
               b = 8'($urandom);
               frame_bytes.push_back(b);
               sum = sum + 16'(b);
            end
            if ($urandom_range(4) == 0) sum = 16'($urandom);
            frame_bytes.push_back(sum[7:0]);
            frame_bytes.push_back(sum[15:8]);
            if ($urandom_range(99) < 8) begin
               cut = $urandom_range(frame_bytes.size() - 1);
               while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
         end
      end
      foreach (frame_bytes[i]) push_byte(frame_bytes[i], 1'b0, '0);
   endtask

   // One random phase: reprogram every register while the block is idle,
   // set the idling rates, optionally start a hold-off, then send items.
   task automatic run_phase(input logic [7:0] sync_a, input logic [7:0] sync_b,
                            input logic [7:0] min_len, input logic [7:0] max_len,
                            input int unsigned gap_pct, input int unsigned stall_pct,
                            input bit with_hold, input int unsigned item_count);
      int unsigned target;
      drain_block();
      csr_write(REG_SYNC_FIRST, sync_a);
      csr_write(REG_SYNC_SECOND, sync_b);
      csr_write(REG_MIN_PAYLOAD, min_len);
      csr_write(REG_MAX_PAYLOAD, max_len);
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      if (with_hold) hold_request = 1'b1;
      target = items_sent + item_count;
      while (items_sent < target) send_random_unit();
   endtask

   function automatic directed_row_t plain_row(input logic [7:0] b);
      directed_row_t row;
      row.rx_byte = b;
      row.pinned  = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   function automatic directed_row_t pinned_row(input logic [7:0] b, input logic [1:0] kind,
                                                input logic [7:0] data,
                                                input logic [31:0] seq,
                                                input logic [7:0] len);
      directed_row_t row;
      row.rx_byte              = b;
      row.pinned               = 1'b1;
      row.want.kind            = kind;
      row.want.payload_byte    = data;
      row.want.frame_sequence  = seq;
      row.want.frame_length    = len;
      row.want.last            = (kind != KIND_PAYLOAD);
      return row;
   endfunction

   initial begin
      logic [7:0] sync_pair;
      logic [7:0] min_len;

      // Every block input is known from time zero.
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'd0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = 4'd0;
      pwdata         = 32'd0;
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b0;
      pin_on         = 1'b0;
      pin_res        = '0;
      items_sent     = 0;
      mismatch_count = 0;

      // The shadow state starts where the block comes out of reset.
      csr_shadow.sync_first  = 8'd0;
      csr_shadow.sync_second = 8'd0;
      csr_shadow.min_payload = 8'd0;
      csr_shadow.max_payload = 8'd255;
      hunt_phase  = PH_HUNT0;
      count_bytes = 8'd0;
      seq_word    = 32'd0;
      held_length = 8'd0;
      byte_sum    = 16'd0;
      check_lo    = 8'd0;
      foreach (header_copy[i]) header_copy[i] = 8'd0;

      // Directed script with sync pair EB 90 and lengths 0 to 2 accepted.
      // The first frame repeats the first sync byte and has zero length, so
      // its checksum follows the length byte; its sum is 0x0185. The second
      // frame has an all-ones sequence, one payload byte of all ones and a
      // zero checksum that does not match. The third frame's length of 3 is
      // out of range; the replay then finds the sync pair that sits inside its
      // sequence field and leaves a new frame part-way through its header.
      script = '{
         plain_row(8'hEB), plain_row(8'hEB), plain_row(8'h90),
         plain_row(8'h01), plain_row(8'h02), plain_row(8'h03), plain_row(8'h04),
         plain_row(8'h00), plain_row(8'h85),
         pinned_row(8'h01, KIND_GOOD, 8'h00, 32'h0403_0201, 8'd0),
         plain_row(8'hEB), plain_row(8'h90),
         plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF), plain_row(8'hFF),
         plain_row(8'h01),
         pinned_row(8'hFF, KIND_PAYLOAD, 8'hFF, 32'hFFFF_FFFF, 8'd1),
         plain_row(8'h00),
         pinned_row(8'h00, KIND_CK_ERR, 8'h00, 32'hFFFF_FFFF, 8'd1),
         plain_row(8'hEB), plain_row(8'h90),
         plain_row(8'hEB), plain_row(8'h90), plain_row(8'h11), plain_row(8'h22),
         pinned_row(8'h03, KIND_LEN_ERR, 8'h00, 32'h2211_90EB, 8'd3)
      };

      // Synchronous reset, held from time zero and released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(REG_SYNC_FIRST, 8'hEB);
      csr_write(REG_SYNC_SECOND, 8'h90);
      csr_write(REG_MIN_PAYLOAD, 8'd0);
      csr_write(REG_MAX_PAYLOAD, 8'd2);
      foreach (script[i]) push_byte(script[i].rx_byte, script[i].pinned, script[i].want);

      // Random phases. The first uses the extreme sync values and the full
      // length range with no idling at all. The second accepts exactly one
      // length with the sender idling often. In the third the minimum is
      // above the maximum, so every length is refused, while the receiver
      // stalls often. In the fourth both sync bytes are equal and both sides
      // idle. The last runs without idling and starts with a long hold-off at
      // the receiver, so the block fills up and holds its input back.
      run_phase(8'hFF, 8'h00, 8'd0, 8'd255, 0, 0, 1'b0, 160);
      min_len = 8'($urandom_range(6));
      run_phase(8'($urandom), 8'($urandom), min_len, min_len, 47, 0, 1'b0, 160);
      run_phase(8'($urandom), 8'($urandom), 8'd200, 8'd10, 0, 47, 1'b0, 160);
      sync_pair = 8'($urandom);
      run_phase(sync_pair, sync_pair, 8'd0, 8'd8, 27, 27, 1'b0, 160);
      min_len = 8'($urandom_range(3));
      run_phase(8'($urandom), 8'($urandom), min_len, 8'(min_len + $urandom_range(10)),
                0, 0, 1'b1, 160);

      // Wind down: wait for every owed result, then give the block time to
      // show anything extra. The watchdog covers a result that never comes.
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sync_length_frame_deframer_sum16_top.f
+incdir+sv
sv/slfd_pkg.sv
sv/slfd_if.sv
sv/slfd_csr.sv
sv/slfd_ctrl.sv
sv/slfd_dp.sv
sv/sync_length_frame_deframer_sum16_top.sv
sv/slfd_checker.sv
tb/tb_sync_length_frame_deframer_sum16_top.sv
